// File: rtl/edt_pkg.sv
// Shared types, constants and helpers for the edit distance block.
package edt_pkg;

  // Default maximum string length in characters.
  localparam int unsigned MaxLenDefault = 64;

  // Fixed field widths.
  localparam int unsigned CharW = 8;
  localparam int unsigned DistW = 7;
  localparam int unsigned DistMax = 127;

  // Command codes carried by func_i.
  typedef enum logic [1:0] {
    FUNC_SRC = 2'd0,
    FUNC_TGT = 2'd1,
    FUNC_CMP = 2'd2
  } func_e;

  // The four characters that one table cell compares.
  typedef struct packed {
    logic [CharW-1:0] s_cur;
    logic [CharW-1:0] s_prev;
    logic [CharW-1:0] t_cur;
    logic [CharW-1:0] t_prev;
  } char_win_t;

  // Row slot of row i-1 when row i sits in slot r (slots rotate modulo three).
  function automatic logic [1:0] row_prev(input logic [1:0] r);
    logic [1:0] res;
    case (r)
      2'd0:    res = 2'd2;
      2'd1:    res = 2'd0;
      2'd2:    res = 2'd1;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

  // Row slot of row i+1, which is also the slot still holding row i-2.
  function automatic logic [1:0] row_next(input logic [1:0] r);
    logic [1:0] res;
    case (r)
      2'd0:    res = 2'd1;
      2'd1:    res = 2'd2;
      2'd2:    res = 2'd0;
      default: res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

// File: rtl/edit_distance_with_transposition.sv
// Edit distance with transposition: loads two strings and returns their distance.
// An append gives no result. A compute with an empty
// string gives its result in the next cycle; otherwise the table walk keeps busy
// high while it computes one cell per cycle within a row through the shared cell
// unit and the row memory, and done_o pulses in the cycle after. The receiver cannot
// stall. Reset clears both lengths, the overflow flag and the sequencer.
module edit_distance_with_transposition import edt_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault,
  localparam int unsigned LW  = $clog2(MAX_LEN + 1),
  localparam int unsigned AW  = $clog2(MAX_LEN),
  localparam int unsigned DAW = LW + 2,
  localparam int unsigned SW  = (LW > DistW) ? LW : DistW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       func_i,
  input  logic [CharW-1:0] char_code_i,
  output logic             done_o,
  output logic [DistW-1:0] distance_o,
  output logic             too_long_o
);

  logic [LW-1:0]    src_len_q, tgt_len_q;
  logic             overflow_q;
  logic             accept, is_src, is_tgt, is_cmp, empty_cmp;
  logic             src_full, tgt_full;
  logic             seq_busy, seq_fin;
  logic [LW-1:0]    seq_dist, res_val;
  logic [SW-1:0]    res_ext;
  logic [AW-1:0]    src_raddr, tgt_raddr;
  logic [CharW-1:0] src_rdata, tgt_rdata;
  logic             dp_we;
  logic [DAW-1:0]   dp_waddr, dp_raddr_up, dp_raddr_up2;
  logic [LW-1:0]    dp_wdata, dp_up, dp_up2;
  logic             done_q;
  logic [DistW-1:0] dist_q;
  logic             too_long_q;

  // Command decode.
  assign accept    = start && !busy;
  assign is_src    = accept && (func_i == FUNC_SRC);
  assign is_tgt    = accept && (func_i == FUNC_TGT);
  assign is_cmp    = accept && (func_i == FUNC_CMP);
  assign src_full  = (src_len_q == LW'(MAX_LEN));
  assign tgt_full  = (tgt_len_q == LW'(MAX_LEN));
  assign empty_cmp = is_cmp && ((src_len_q == '0) || (tgt_len_q == '0));

  // String stores.
  edt_char_mem #(
    .MAX_LEN (MAX_LEN)
  ) u_src_mem (
    .clk_i   (clk_i),
    .we_i    (is_src && !src_full),
    .waddr_i (src_len_q[AW-1:0]),
    .wdata_i (char_code_i),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  edt_char_mem #(
    .MAX_LEN (MAX_LEN)
  ) u_tgt_mem (
    .clk_i   (clk_i),
    .we_i    (is_tgt && !tgt_full),
    .waddr_i (tgt_len_q[AW-1:0]),
    .wdata_i (char_code_i),
    .raddr_i (tgt_raddr),
    .rdata_o (tgt_rdata)
  );

  // Rolling table rows.
  edt_dp_mem #(
    .MAX_LEN (MAX_LEN)
  ) u_dp_mem (
    .clk_i     (clk_i),
    .we_i      (dp_we),
    .waddr_i   (dp_waddr),
    .wdata_i   (dp_wdata),
    .raddr_a_i (dp_raddr_up),
    .raddr_b_i (dp_raddr_up2),
    .rdata_a_o (dp_up),
    .rdata_b_o (dp_up2)
  );

  // Table walk.
  edt_seq #(
    .MAX_LEN (MAX_LEN)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .go_i           (is_cmp && !empty_cmp),
    .src_len_i      (src_len_q),
    .tgt_len_i      (tgt_len_q),
    .src_addr_o     (src_raddr),
    .src_char_i     (src_rdata),
    .tgt_addr_o     (tgt_raddr),
    .tgt_char_i     (tgt_rdata),
    .dp_we_o        (dp_we),
    .dp_waddr_o     (dp_waddr),
    .dp_wdata_o     (dp_wdata),
    .dp_raddr_up_o  (dp_raddr_up),
    .dp_raddr_up2_o (dp_raddr_up2),
    .dp_up_i        (dp_up),
    .dp_up2_i       (dp_up2),
    .busy_o         (seq_busy),
    .fin_o          (seq_fin),
    .fin_dist_o     (seq_dist)
  );

  assign busy = seq_busy;

  // Result value: the other length for an empty string, then saturation.
  assign res_val = empty_cmp ? (src_len_q | tgt_len_q) : seq_dist;
  assign res_ext = SW'(res_val);

  // Lengths and overflow flag; cleared once a result beat is produced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_len_q  <= '0;
      tgt_len_q  <= '0;
      overflow_q <= 1'b0;
    end else if (empty_cmp || seq_fin) begin
      src_len_q  <= '0;
      tgt_len_q  <= '0;
      overflow_q <= 1'b0;
    end else if (is_src) begin
      if (src_full) begin
        overflow_q <= 1'b1;
      end else begin
        src_len_q <= src_len_q + LW'(1);
      end
    end else if (is_tgt) begin
      if (tgt_full) begin
        overflow_q <= 1'b1;
      end else begin
        tgt_len_q <= tgt_len_q + LW'(1);
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= empty_cmp || seq_fin;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (empty_cmp || seq_fin) begin
      dist_q     <= (res_ext > SW'(DistMax)) ? DistW'(DistMax) : res_ext[DistW-1:0];
      too_long_q <= overflow_q;
    end
  end

  assign done_o     = done_q;
  assign distance_o = dist_q;
  assign too_long_o = too_long_q;

  // A result beat only appears while the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result beat while busy");

  // A result beat follows the clearing of both strings.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (src_len_q == '0) && (tgt_len_q == '0) && !overflow_q)
    else $error("strings not cleared after result");

  // The table walk only starts on an accepted compute command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (func_i == FUNC_CMP)))
    else $error("busy without compute command");

  // Lengths stay within the string capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (src_len_q <= LW'(MAX_LEN)) && (tgt_len_q <= LW'(MAX_LEN)))
    else $error("string length beyond capacity");

endmodule

// File: rtl/edt_char_mem.sv
// Character store for one string: one write port, one registered read port.
module edt_char_mem import edt_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault,
  localparam int unsigned AW = $clog2(MAX_LEN)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [CharW-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [CharW-1:0] rdata_o
);

  logic [CharW-1:0] mem_q [MAX_LEN];

  // Write on append.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/edt_dp_mem.sv
// Rolling table rows: one write port and two registered read ports.
module edt_dp_mem import edt_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault,
  localparam int unsigned LW  = $clog2(MAX_LEN + 1),
  localparam int unsigned DAW = LW + 2
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [DAW-1:0] waddr_i,
  input  logic [LW-1:0]  wdata_i,
  input  logic [DAW-1:0] raddr_a_i,
  input  logic [DAW-1:0] raddr_b_i,
  output logic [LW-1:0]  rdata_a_o,
  output logic [LW-1:0]  rdata_b_o
);

  logic [LW-1:0] mem_q [2**DAW];

  // Write the cell just computed.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered reads: the row above and the row two above.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/edt_cell_unit.sv
// Shared cell unit: compares, adds and takes the minimum for one table cell.
module edt_cell_unit import edt_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault,
  localparam int unsigned LW = $clog2(MAX_LEN + 1),
  localparam int unsigned EW = LW + 2
) (
  input  logic [LW-1:0] up_i,
  input  logic [LW-1:0] left_i,
  input  logic [LW-1:0] diag_i,
  input  logic [LW-1:0] up2_i,
  input  char_win_t     chars_i,
  input  logic          trans_en_i,
  output logic [LW-1:0] cell_o
);

  logic [EW-1:0] del_w, ins_w, sub_w, trans_w, min_a, min_b;
  logic          cost_w, cross_a, cross_b;

  // Character compares.
  assign cost_w  = (chars_i.s_cur != chars_i.t_cur);
  assign cross_a = (chars_i.s_prev != chars_i.t_cur);
  assign cross_b = (chars_i.s_cur != chars_i.t_prev);

  // Candidate costs.
  assign del_w   = EW'(up_i) + EW'(1);
  assign ins_w   = EW'(left_i) + EW'(1);
  assign sub_w   = EW'(diag_i) + EW'(cost_w);
  assign trans_w = EW'(up2_i) + EW'(1) + EW'(cross_a) + EW'(cross_b);

  // Minimum; the result never exceeds the longer string length.
  always_comb begin
    min_a = (del_w < ins_w) ? del_w : ins_w;
    min_b = (sub_w < min_a) ? sub_w : min_a;
    if (trans_en_i && (trans_w < min_b)) begin
      min_b = trans_w;
    end
    cell_o = min_b[LW-1:0];
  end

endmodule

// File: rtl/edt_seq.sv
// Sequencer that walks the distance table one cell per cycle within a row.
module edt_seq import edt_pkg::*; #(
  parameter int unsigned MAX_LEN = MaxLenDefault,
  localparam int unsigned LW  = $clog2(MAX_LEN + 1),
  localparam int unsigned AW  = $clog2(MAX_LEN),
  localparam int unsigned DAW = LW + 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [LW-1:0]    src_len_i,
  input  logic [LW-1:0]    tgt_len_i,
  output logic [AW-1:0]    src_addr_o,
  input  logic [CharW-1:0] src_char_i,
  output logic [AW-1:0]    tgt_addr_o,
  input  logic [CharW-1:0] tgt_char_i,
  output logic             dp_we_o,
  output logic [DAW-1:0]   dp_waddr_o,
  output logic [LW-1:0]    dp_wdata_o,
  output logic [DAW-1:0]   dp_raddr_up_o,
  output logic [DAW-1:0]   dp_raddr_up2_o,
  input  logic [LW-1:0]    dp_up_i,
  input  logic [LW-1:0]    dp_up2_i,
  output logic             busy_o,
  output logic             fin_o,
  output logic [LW-1:0]    fin_dist_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_INIT  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_ROW   = 5'b01000,
    ST_CELL  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [LW-1:0]    i_q, i_d, j_q, j_d;
  logic [1:0]       row_q, row_d;
  logic [CharW-1:0] s_cur_q, s_prev_q, t_prev_q;
  logic [LW-1:0]    left_q, diag_q, p1_q, p2_q;
  logic [LW-1:0]    cell_w, j_inc;
  logic             trans_en;
  char_win_t        chars_w;

  assign j_inc = j_q + LW'(1);

  // Characters for the current cell.
  assign chars_w.s_cur  = s_cur_q;
  assign chars_w.s_prev = s_prev_q;
  assign chars_w.t_cur  = tgt_char_i;
  assign chars_w.t_prev = t_prev_q;
  assign trans_en = (i_q > LW'(2)) && (j_q > LW'(2));

  edt_cell_unit #(
    .MAX_LEN (MAX_LEN)
  ) u_cell (
    .up_i       (dp_up_i),
    .left_i     (left_q),
    .diag_i     (diag_q),
    .up2_i      (p2_q),
    .chars_i    (chars_w),
    .trans_en_i (trans_en),
    .cell_o     (cell_w)
  );

  // Next state, counters and memory addressing.
  always_comb begin
    state_d        = state_q;
    i_d            = i_q;
    j_d            = j_q;
    row_d          = row_q;
    src_addr_o     = AW'(i_q - LW'(1));
    tgt_addr_o     = j_q[AW-1:0];
    dp_we_o        = 1'b0;
    dp_waddr_o     = {row_q, j_q};
    dp_wdata_o     = cell_w;
    dp_raddr_up_o  = {row_prev(row_q), j_inc};
    dp_raddr_up2_o = {row_next(row_q), j_inc};
    fin_o          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          j_d     = '0;
          row_d   = 2'd0;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        dp_we_o    = 1'b1;
        dp_waddr_o = {2'd0, j_q};
        dp_wdata_o = j_q;
        if (j_q == tgt_len_i) begin
          i_d     = LW'(1);
          row_d   = 2'd1;
          state_d = ST_FETCH;
        end else begin
          j_d = j_inc;
        end
      end
      ST_FETCH: begin
        state_d = ST_ROW;
      end
      ST_ROW: begin
        // Column zero of row i, and prefetch of column one.
        dp_we_o        = 1'b1;
        dp_waddr_o     = {row_q, LW'(0)};
        dp_wdata_o     = i_q;
        tgt_addr_o     = '0;
        dp_raddr_up_o  = {row_prev(row_q), LW'(1)};
        dp_raddr_up2_o = {row_next(row_q), LW'(1)};
        j_d            = LW'(1);
        state_d        = ST_CELL;
      end
      ST_CELL: begin
        dp_we_o = 1'b1;
        if (j_q == tgt_len_i) begin
          if (i_q == src_len_i) begin
            fin_o   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + LW'(1);
            row_d   = row_next(row_q);
            state_d = ST_FETCH;
          end
        end else begin
          j_d = j_inc;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      row_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      row_q   <= row_d;
    end
  end

  // Operand holding registers for the cell unit.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ROW) begin
      s_cur_q  <= src_char_i;
      s_prev_q <= s_cur_q;
      left_q   <= i_q;
      diag_q   <= i_q - LW'(1);
      p1_q     <= i_q - LW'(2);
    end else if (state_q == ST_CELL) begin
      left_q   <= cell_w;
      diag_q   <= dp_up_i;
      p2_q     <= p1_q;
      p1_q     <= dp_up2_i;
      t_prev_q <= tgt_char_i;
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign fin_dist_o = cell_w;

endmodule
